// File: hw/rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the surface patch filter
// Register map, configuration bundle, side data carried down the pipeline
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package spf_pkg;

  // register index, byte address 8*index
  typedef enum logic [2:0] {
    REG_ENABLES   = 3'd0,
    REG_TARGET    = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_CURV_MIN  = 3'd3,
    REG_CURV_MAX  = 3'd4,
    REG_VIEWPOINT = 3'd5,
    REG_SLOPE_DIR = 3'd6,
    REG_MAX_SLOPE = 3'd7
  } reg_idx_t;

  // bit positions in the enables register
  localparam int ENA_DIST  = 0;
  localparam int ENA_CURV  = 1;
  localparam int ENA_SLOPE = 2;

  typedef struct packed {
    logic [2:0]         enables;
    logic [62:0]        target;
    logic [21:0]        radius;
    logic signed [23:0] curv_min;
    logic signed [23:0] curv_max;
    logic [62:0]        viewpoint;
    logic [47:0]        slope_dir;
    logic [15:0]        slope_limit;
  } cfg_t;

  // per-item flags that ride along with the arithmetic
  typedef struct packed {
    logic        pvalid;
    logic [15:0] index;
    logic        pdist;
    logic        pcurv;
  } side_t;

  localparam int CRD_W   = 56;
  localparam int Z_W     = 28;
  localparam int CRD_N   = 24;
  localparam int DSQ_N   = 23;
  localparam int CSQ_N   = 32;

  // atan(2^-i) in units of pi/2^24
  localparam logic [22:0] ATAN_TAB [0:23] = '{
    23'd4194304, 23'd2476042, 23'd1308273, 23'd664100, 23'd333339, 23'd166832,
    23'd83436,   23'd41721,   23'd20861,   23'd10430,  23'd5215,   23'd2608,
    23'd1304,    23'd652,     23'd326,     23'd163,    23'd81,     23'd41,
    23'd20,      23'd10,      23'd5,       23'd3,      23'd1,      23'd1
  };

endpackage

// File: hw/rtl/spf_cfg.sv
// ----------------------------------------------------------------------------
// spf_cfg: configuration register file
// APB-style slave, 64-bit data, one register every 8 bytes.
// ----------------------------------------------------------------------------
module spf_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output spf_pkg::cfg_t     cfg
);

  logic              wr;
  spf_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = spf_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        spf_pkg::REG_ENABLES:   cfg.enables     <= pwdata[2:0];
        spf_pkg::REG_TARGET:    cfg.target      <= pwdata[62:0];
        spf_pkg::REG_RADIUS:    cfg.radius      <= pwdata[21:0];
        spf_pkg::REG_CURV_MIN:  cfg.curv_min    <= pwdata[23:0];
        spf_pkg::REG_CURV_MAX:  cfg.curv_max    <= pwdata[23:0];
        spf_pkg::REG_VIEWPOINT: cfg.viewpoint   <= pwdata[62:0];
        spf_pkg::REG_SLOPE_DIR: cfg.slope_dir   <= pwdata[47:0];
        spf_pkg::REG_MAX_SLOPE: cfg.slope_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spf_pkg::REG_ENABLES:   prdata = {61'd0, cfg.enables};
      spf_pkg::REG_TARGET:    prdata = {1'b0, cfg.target};
      spf_pkg::REG_RADIUS:    prdata = {42'd0, cfg.radius};
      spf_pkg::REG_CURV_MIN:  prdata = {40'd0, cfg.curv_min};
      spf_pkg::REG_CURV_MAX:  prdata = {40'd0, cfg.curv_max};
      spf_pkg::REG_VIEWPOINT: prdata = {1'b0, cfg.viewpoint};
      spf_pkg::REG_SLOPE_DIR: prdata = {16'd0, cfg.slope_dir};
      spf_pkg::REG_MAX_SLOPE: prdata = {48'd0, cfg.slope_limit};
      default:                prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/surface_patch_filter_unit.sv
// ----------------------------------------------------------------------------
// surface_patch_filter_unit: streaming surface patch selector
// Distance, curvature and slope tests on one patch per beat.
// ----------------------------------------------------------------------------
// Throughput: one patch per cycle; 5 arithmetic stages, 32 square root
// digit stages, one setup stage, 24 CORDIC stages and the output register.
// The whole pipeline advances together and holds while the output is stalled.
// Reset (synchronous) clears the valid bits and the configuration registers
// and holds s_tready low; data registers keep their contents.
module surface_patch_filter_unit (
  input  logic         clk,
  input  logic         rst,
  // index[15:0], centre_x[36:16], centre_y[57:37], centre_z[78:58],
  // normal_x[94:79], normal_y[110:95], normal_z[126:111],
  // curv_first[150:127], curv_second[174:151]
  input  logic [175:0] s_tdata,
  input  logic [0:0]   s_tuser,   // patch_valid[0]
  input  logic         s_tvalid,
  output logic         s_tready,
  // out_index[15:0], distance[37:16]
  output logic [39:0]  m_tdata,
  output logic [0:0]   m_tuser,   // selected[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int CW = spf_pkg::CRD_W;
  localparam int ZW = spf_pkg::Z_W;

  spf_pkg::cfg_t cfg;
  logic          ce;

  spf_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign ce       = ~m_tvalid | m_tready;
  assign s_tready = ce & ~rst;

  // ---------------- stage A: differences ----------------
  logic                a_vld;
  spf_pkg::side_t      a_side;
  logic signed [21:0]  a_dx, a_dy, a_dz, a_vx, a_vy, a_vz;
  logic signed [15:0]  a_nx, a_ny, a_nz;
  logic signed [23:0]  a_k1, a_k2;

  logic signed [20:0] in_cx, in_cy, in_cz;
  assign in_cx = s_tdata[36:16];
  assign in_cy = s_tdata[57:37];
  assign in_cz = s_tdata[78:58];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (ce) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_side.pvalid <= s_tuser[0];
      a_side.index  <= s_tdata[15:0];
      a_side.pdist  <= 1'b0;
      a_side.pcurv  <= 1'b0;
      a_dx <= 22'($signed(cfg.target[20:0]))    - 22'(in_cx);
      a_dy <= 22'($signed(cfg.target[41:21]))   - 22'(in_cy);
      a_dz <= 22'($signed(cfg.target[62:42]))   - 22'(in_cz);
      a_vx <= 22'($signed(cfg.viewpoint[20:0])) - 22'(in_cx);
      a_vy <= 22'($signed(cfg.viewpoint[41:21])) - 22'(in_cy);
      a_vz <= 22'($signed(cfg.viewpoint[62:42])) - 22'(in_cz);
      a_nx <= s_tdata[94:79];
      a_ny <= s_tdata[110:95];
      a_nz <= s_tdata[126:111];
      a_k1 <= s_tdata[150:127];
      a_k2 <= s_tdata[174:151];
    end
  end

  // ---------------- stage B: products ----------------
  logic signed [15:0] sx, sy, sz;
  assign sx = cfg.slope_dir[15:0];
  assign sy = cfg.slope_dir[31:16];
  assign sz = cfg.slope_dir[47:32];

  logic                b_vld;
  spf_pkg::side_t      b_side;
  logic signed [43:0]  b_sqx, b_sqy, b_sqz;
  logic [43:0]         b_r2;
  logic signed [37:0]  b_vpx, b_vpy, b_vpz;
  logic signed [31:0]  b_dpx, b_dpy, b_dpz;
  logic signed [31:0]  b_p12, b_p21, b_p20, b_p02, b_p01, b_p10;
  logic signed [23:0]  kmin, kmax;
  logic                curv_ok;

  assign kmin    = (a_k1 < a_k2) ? a_k1 : a_k2;
  assign kmax    = (a_k1 < a_k2) ? a_k2 : a_k1;
  assign curv_ok = ~((kmax > cfg.curv_max) | (kmin < cfg.curv_min));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (ce) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_side <= {a_side.pvalid, a_side.index, a_side.pdist, curv_ok};
      b_sqx <= a_dx * a_dx;
      b_sqy <= a_dy * a_dy;
      b_sqz <= a_dz * a_dz;
      b_r2  <= cfg.radius * cfg.radius;
      b_vpx <= a_vx * a_nx;
      b_vpy <= a_vy * a_ny;
      b_vpz <= a_vz * a_nz;
      b_dpx <= a_nx * sx;
      b_dpy <= a_ny * sy;
      b_dpz <= a_nz * sz;
      b_p12 <= a_ny * sz;
      b_p21 <= a_nz * sy;
      b_p20 <= a_nz * sx;
      b_p02 <= a_nx * sz;
      b_p01 <= a_nx * sy;
      b_p10 <= a_ny * sx;
    end
  end

  // ---------------- stage C: sums ----------------
  logic                c_vld;
  spf_pkg::side_t      c_side;
  logic [45:0]         c_d2;
  logic signed [39:0]  c_vdot;
  logic signed [33:0]  c_dot;
  logic signed [32:0]  c_cx, c_cy, c_cz;
  logic [45:0]         d2_sum;
  logic                dist_ok;

  assign d2_sum  = 46'(b_sqx[43:0]) + 46'(b_sqy[43:0]) + 46'(b_sqz[43:0]);
  assign dist_ok = (d2_sum <= {2'b00, b_r2});

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (ce) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c_side <= {b_side.pvalid, b_side.index, dist_ok, b_side.pcurv};
      c_d2   <= d2_sum;
      c_vdot <= 40'(b_vpx) + 40'(b_vpy) + 40'(b_vpz);
      c_dot  <= 34'(b_dpx) + 34'(b_dpy) + 34'(b_dpz);
      c_cx   <= 33'(b_p12) - 33'(b_p21);
      c_cy   <= 33'(b_p20) - 33'(b_p02);
      c_cz   <= 33'(b_p01) - 33'(b_p10);
    end
  end

  // ---------------- stage D: flip and cross squares ----------------
  logic                d_vld;
  spf_pkg::side_t      d_side;
  logic [45:0]         d_d2;
  logic signed [34:0]  d_x0;
  logic signed [63:0]  d_sqx, d_sqy, d_sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (ce) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_side <= c_side;
      d_d2   <= c_d2;
      d_x0   <= c_vdot[39] ? -35'(c_dot) : 35'(c_dot);
      d_sqx  <= c_cx * c_cx;
      d_sqy  <= c_cy * c_cy;
      d_sqz  <= c_cz * c_cz;
    end
  end

  // ---------------- stage E and square root digit stages ----------------
  logic                q_vld  [0:32];
  spf_pkg::side_t      q_side [0:32];
  logic [45:0]         q_dv   [0:32];
  logic [22:0]         q_dr   [0:32];
  logic [25:0]         q_drem [0:32];
  logic [63:0]         q_cv   [0:32];
  logic [31:0]         q_cr   [0:32];
  logic [34:0]         q_crem [0:32];
  logic signed [34:0]  q_x0   [0:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld[0] <= 1'b0;
    end else if (ce) begin
      q_vld[0] <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      q_side[0] <= d_side;
      q_dv[0]   <= d_d2;
      q_dr[0]   <= '0;
      q_drem[0] <= '0;
      q_cv[0]   <= d_sqx + d_sqy + d_sqz;
      q_cr[0]   <= '0;
      q_crem[0] <= '0;
      q_x0[0]   <= d_x0;
    end
  end

  for (genvar k = 1; k <= spf_pkg::CSQ_N; k++) begin : g_sqrt
    logic [34:0] c_sh, c_tr;
    logic        c_ge;

    assign c_sh = {q_crem[k-1][32:0], q_cv[k-1][63:62]};
    assign c_tr = {1'b0, q_cr[k-1], 2'b01};
    assign c_ge = (c_sh >= c_tr);

    always_ff @(posedge clk) begin
      if (rst) begin
        q_vld[k] <= 1'b0;
      end else if (ce) begin
        q_vld[k] <= q_vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        q_side[k] <= q_side[k-1];
        q_x0[k]   <= q_x0[k-1];
        q_cv[k]   <= {q_cv[k-1][61:0], 2'b00};
        q_cr[k]   <= {q_cr[k-1][30:0], c_ge};
        q_crem[k] <= c_ge ? (c_sh - c_tr) : c_sh;
      end
    end

    if (k <= spf_pkg::DSQ_N) begin : g_dist
      logic [25:0] d_sh, d_tr;
      logic        d_ge;

      assign d_sh = {q_drem[k-1][23:0], q_dv[k-1][45:44]};
      assign d_tr = {1'b0, q_dr[k-1], 2'b01};
      assign d_ge = (d_sh >= d_tr);

      always_ff @(posedge clk) begin
        if (ce) begin
          q_dv[k]   <= {q_dv[k-1][43:0], 2'b00};
          q_dr[k]   <= {q_dr[k-1][21:0], d_ge};
          q_drem[k] <= d_ge ? (d_sh - d_tr) : d_sh;
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (ce) begin
          q_dv[k]   <= q_dv[k-1];
          q_dr[k]   <= q_dr[k-1];
          q_drem[k] <= q_drem[k-1];
        end
      end
    end
  end

  // ---------------- CORDIC setup and vectoring stages ----------------
  logic                r_vld   [0:24];
  spf_pkg::side_t      r_side  [0:24];
  logic [21:0]         r_dist  [0:24];
  logic                r_yzero [0:24];
  logic signed [CW-1:0] r_x    [0:24];
  logic signed [CW-1:0] r_y    [0:24];
  logic signed [ZW-1:0] r_z    [0:24];

  logic                 xneg;
  logic signed [CW-1:0] y_ext, x_ext, x_init, y_init;

  assign xneg   = q_x0[32][34];
  assign y_ext  = CW'($signed({1'b0, q_cr[32]}));
  assign x_ext  = CW'(q_x0[32]);
  assign x_init = xneg ? y_ext : x_ext;
  assign y_init = xneg ? -x_ext : y_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld[0] <= 1'b0;
    end else if (ce) begin
      r_vld[0] <= q_vld[32];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r_side[0]  <= q_side[32];
      r_dist[0]  <= q_dr[32][22] ? '1 : q_dr[32][21:0];
      r_yzero[0] <= (q_cr[32] == '0);
      r_x[0]     <= x_init <<< 20;
      r_y[0]     <= y_init <<< 20;
      // rotated by a quarter turn: start the angle at pi/2
      r_z[0]     <= xneg ? ZW'(32'sd8388608) : '0;
    end
  end

  for (genvar k = 1; k <= spf_pkg::CRD_N; k++) begin : g_cordic
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] tz;

    assign xs = r_x[k-1] >>> (k - 1);
    assign ys = r_y[k-1] >>> (k - 1);
    assign tz = ZW'($signed({1'b0, spf_pkg::ATAN_TAB[k-1]}));

    always_ff @(posedge clk) begin
      if (rst) begin
        r_vld[k] <= 1'b0;
      end else if (ce) begin
        r_vld[k] <= r_vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        r_side[k]  <= r_side[k-1];
        r_dist[k]  <= r_dist[k-1];
        r_yzero[k] <= r_yzero[k-1];
        if (!r_y[k-1][CW-1]) begin
          r_x[k] <= r_x[k-1] + ys;
          r_y[k] <= r_y[k-1] - xs;
          r_z[k] <= r_z[k-1] + tz;
        end else begin
          r_x[k] <= r_x[k-1] - ys;
          r_y[k] <= r_y[k-1] + xs;
          r_z[k] <= r_z[k-1] - tz;
        end
      end
    end
  end

  // ---------------- angle, decision and output register ----------------
  logic [ZW-2:0] z_pos;
  logic [ZW-1:0] z_rnd;
  logic [18:0]   ang_w;
  logic [15:0]   ang;
  logic          pslope, sel;
  spf_pkg::side_t fs;

  assign fs     = r_side[24];
  assign z_pos  = r_z[24][ZW-1] ? '0 : r_z[24][ZW-2:0];
  assign z_rnd  = {1'b0, z_pos} + ZW'(256);
  assign ang_w  = z_rnd[ZW-1:9];
  assign ang    = (ang_w > 19'd32768) ? 16'd32768 : ang_w[15:0];
  assign pslope = r_yzero[24] | (ang == 16'd32768) | (ang <= cfg.slope_limit);
  assign sel    = fs.pvalid & (~cfg.enables[spf_pkg::ENA_DIST] | fs.pdist)
                & (~cfg.enables[spf_pkg::ENA_CURV] | fs.pcurv)
                & (~cfg.enables[spf_pkg::ENA_SLOPE] | pslope);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= r_vld[24];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {2'b00, r_dist[24], fs.index};
      m_tuser <= sel;
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_tail_holds: assert property (@(posedge clk) disable iff (rst)
    (r_vld[24] && !ce) |=> r_vld[24])
    else $error("pipeline tail dropped a beat during stall");
`endif

endmodule
